// ===== design/utf8_text_validator_assert.svh =====
// ----------------------------------------------------------------------------
// UTF-8 text validator assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef UTF8_TEXT_VALIDATOR_ASSERT_SVH
`define UTF8_TEXT_VALIDATOR_ASSERT_SVH

`ifndef SYNTH
`define UTV_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("utf8_text_validator: same-cycle check failed");
`define UTV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("utf8_text_validator: next-cycle check failed");
`else
`define UTV_ASSERT_IMPLY(lbl, ante, cons)
`define UTV_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/utv_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 text validator package
// Beat types, per-text state and fault codes shared by the validator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package utv_pkg;

    localparam logic [2:0] FAULT_NONE = 3'd0;
    localparam logic [2:0] FAULT_LONG = 3'd1;
    localparam logic [2:0] FAULT_CTRL = 3'd2;
    localparam logic [2:0] FAULT_LEAD = 3'd3;
    localparam logic [2:0] FAULT_CONT = 3'd4;
    localparam logic [2:0] FAULT_CODE = 3'd5;

    localparam logic CFG_MAX_LENGTH        = 1'b0;
    localparam logic CFG_ALLOW_TAB_NEWLINE = 1'b1;

    localparam logic [12:0] COUNT_SAT       = 13'd8191;
    localparam logic [11:0] MAX_LENGTH_RST  = 12'd4095;

    localparam logic [20:0] CP_MIN_TWO      = 21'h00080;
    localparam logic [20:0] CP_MIN_THREE    = 21'h00800;
    localparam logic [20:0] CP_MIN_FOUR     = 21'h10000;
    localparam logic [20:0] CP_MAX          = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO      = 21'h0D800;
    localparam logic [20:0] CP_SURR_HI      = 21'h0DFFF;

    localparam logic [7:0] BYTE_SPACE       = 8'd32;
    localparam logic [7:0] BYTE_TAB         = 8'd9;
    localparam logic [7:0] BYTE_NEWLINE     = 8'd10;
    localparam logic [7:0] BYTE_DEL         = 8'd127;
    localparam logic [7:0] LEAD_TWO_LO      = 8'hC2;
    localparam logic [7:0] LEAD_TWO_HI      = 8'hDF;
    localparam logic [7:0] LEAD_THREE_LO    = 8'hE0;
    localparam logic [7:0] LEAD_THREE_HI    = 8'hEF;
    localparam logic [7:0] LEAD_FOUR_LO     = 8'hF0;
    localparam logic [7:0] LEAD_FOUR_HI     = 8'hF4;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in_beat;

    typedef struct packed {
        logic       text_ok;
        logic [2:0] fault_kind;
    } t_out_beat;

    typedef struct packed {
        logic [2:0]  first_fault;
        logic [1:0]  bytes_still_needed;
        logic [20:0] partial_code_point;
        logic [1:0]  sequence_class;
    } t_text_state;

endpackage

`default_nettype wire

// ===== design/utv_byte_step.sv =====
// ----------------------------------------------------------------------------
// UTF-8 byte step
// Combinational decode of one text byte against the running sequence state.
// ----------------------------------------------------------------------------
`default_nettype none

module utv_byte_step (
    input  wire utv_pkg::t_text_state i_state,
    input  wire logic [7:0]           i_text_byte,
    input  wire logic                 i_allow_tab_newline,
    output utv_pkg::t_text_state      o_state
);

    logic [20:0] code_point;
    logic [20:0] min_point;
    logic        point_bad;

    assign code_point = {i_state.partial_code_point[14:0], i_text_byte[5:0]};

    always_comb begin
        unique case (i_state.sequence_class)
            2'd1:    min_point = utv_pkg::CP_MIN_TWO;
            2'd2:    min_point = utv_pkg::CP_MIN_THREE;
            default: min_point = utv_pkg::CP_MIN_FOUR;
        endcase
    end

    assign point_bad = (code_point < min_point) || (code_point > utv_pkg::CP_MAX)
                    || ((code_point >= utv_pkg::CP_SURR_LO)
                        && (code_point <= utv_pkg::CP_SURR_HI));

    always_comb begin
        o_state = i_state;
        if (i_state.first_fault == utv_pkg::FAULT_NONE) begin
            if (i_state.bytes_still_needed != 2'd0) begin
                if (i_text_byte[7:6] != 2'b10) begin
                    o_state.first_fault = utv_pkg::FAULT_CONT;
                end else begin
                    o_state.partial_code_point = code_point;
                    o_state.bytes_still_needed = i_state.bytes_still_needed - 2'd1;
                    if (i_state.bytes_still_needed == 2'd1) begin
                        if (point_bad) begin
                            o_state.first_fault = utv_pkg::FAULT_CODE;
                        end
                        o_state.partial_code_point = '0;
                        o_state.sequence_class     = 2'd0;
                    end
                end
            end else if (i_text_byte < utv_pkg::BYTE_SPACE) begin
                if (!(i_allow_tab_newline && (i_text_byte == utv_pkg::BYTE_TAB
                                              || i_text_byte == utv_pkg::BYTE_NEWLINE))) begin
                    o_state.first_fault = utv_pkg::FAULT_CTRL;
                end
            end else if (i_text_byte == utv_pkg::BYTE_DEL) begin
                o_state.first_fault = utv_pkg::FAULT_CTRL;
            end else if (!i_text_byte[7]) begin
                o_state = i_state;
            end else if (i_text_byte >= utv_pkg::LEAD_TWO_LO
                         && i_text_byte <= utv_pkg::LEAD_TWO_HI) begin
                o_state.bytes_still_needed = 2'd1;
                o_state.sequence_class     = 2'd1;
                o_state.partial_code_point = {16'd0, i_text_byte[4:0]};
            end else if (i_text_byte >= utv_pkg::LEAD_THREE_LO
                         && i_text_byte <= utv_pkg::LEAD_THREE_HI) begin
                o_state.bytes_still_needed = 2'd2;
                o_state.sequence_class     = 2'd2;
                o_state.partial_code_point = {17'd0, i_text_byte[3:0]};
            end else if (i_text_byte >= utv_pkg::LEAD_FOUR_LO
                         && i_text_byte <= utv_pkg::LEAD_FOUR_HI) begin
                o_state.bytes_still_needed = 2'd3;
                o_state.sequence_class     = 2'd3;
                o_state.partial_code_point = {18'd0, i_text_byte[2:0]};
            end else begin
                o_state.first_fault = utv_pkg::FAULT_LEAD;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/utf8_text_validator.sv =====
// ----------------------------------------------------------------------------
// UTF-8 text validator
// Checks a byte stream for well-formed UTF-8, control bytes and text length.
// ----------------------------------------------------------------------------
// The validator takes one text byte per cycle and gives one verdict beat on
// the byte flagged as final; other bytes give no beat. Each byte is decoded
// combinationally against the registered sequence state, so a new byte can
// be taken every clock while ready is high. Verdicts go to an output register
// backed by one skid register, and input ready drops only while both of them
// hold verdicts that have not been taken. The length limit is the smaller of
// max_length and LENGTH_LIMIT_MAX; configuration writes take effect at once and
// belong between texts.
`default_nettype none

module utf8_text_validator #(
    parameter int unsigned LENGTH_LIMIT_MAX = 4095
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire utv_pkg::t_in_beat i_in_beat,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output utv_pkg::t_out_beat     o_out_beat,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [11:0]       i_cfg_data
);

    localparam logic [15:0] LimitCap = 16'(LENGTH_LIMIT_MAX);

    logic [11:0]          r_max_length;
    logic                 r_allow_tab_newline;
    logic [12:0]          r_byte_count;
    logic [12:0]          n_byte_count;
    utv_pkg::t_text_state r_state;
    utv_pkg::t_text_state n_state;
    utv_pkg::t_text_state step_state;

    logic                 r_out_valid;
    logic                 n_out_valid;
    utv_pkg::t_out_beat   r_out_beat;
    utv_pkg::t_out_beat   n_out_beat;
    logic                 r_skid_valid;
    logic                 n_skid_valid;
    utv_pkg::t_out_beat   r_skid_beat;
    utv_pkg::t_out_beat   n_skid_beat;

    logic                 in_take;
    logic                 out_take;
    logic                 emit;
    logic [15:0]          limit;
    logic                 too_long;
    logic [2:0]           verdict;
    utv_pkg::t_out_beat   result;

    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    assign in_take  = i_in_valid && o_in_ready;
    assign out_take = r_out_valid && i_out_ready;
    assign emit     = in_take && i_in_beat.final_byte;

    utv_byte_step u_step (
        .i_state             (r_state),
        .i_text_byte         (i_in_beat.text_byte),
        .i_allow_tab_newline (r_allow_tab_newline),
        .o_state             (step_state)
    );

    assign n_byte_count = (r_byte_count < utv_pkg::COUNT_SAT) ? r_byte_count + 13'd1
                                                               : r_byte_count;
    assign limit    = ({4'd0, r_max_length} < LimitCap) ? {4'd0, r_max_length} : LimitCap;
    assign too_long = {3'd0, n_byte_count} > limit;

    always_comb begin
        if (too_long) begin
            verdict = utv_pkg::FAULT_LONG;
        end else if (step_state.first_fault != utv_pkg::FAULT_NONE) begin
            verdict = step_state.first_fault;
        end else if (step_state.bytes_still_needed != 2'd0) begin
            verdict = utv_pkg::FAULT_CONT;
        end else begin
            verdict = utv_pkg::FAULT_NONE;
        end
        result.text_ok    = (verdict == utv_pkg::FAULT_NONE);
        result.fault_kind = verdict;
    end

    always_comb begin
        n_state = r_state;
        if (in_take) begin
            n_state = i_in_beat.final_byte ? '0 : step_state;
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_beat   = r_out_beat;
        n_skid_valid = r_skid_valid;
        n_skid_beat  = r_skid_beat;
        if (out_take) begin
            n_out_valid = r_skid_valid;
            n_out_beat  = r_skid_beat;
            n_skid_valid = 1'b0;
        end
        if (emit) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out_beat  = result;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_beat  = result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length        <= utv_pkg::MAX_LENGTH_RST;
            r_allow_tab_newline <= 1'b0;
            r_byte_count        <= '0;
            r_state             <= '0;
            r_out_valid         <= 1'b0;
            r_skid_valid        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    utv_pkg::CFG_MAX_LENGTH:        r_max_length <= i_cfg_data;
                    utv_pkg::CFG_ALLOW_TAB_NEWLINE: r_allow_tab_newline <= i_cfg_data[0];
                    default:                        r_allow_tab_newline <= r_allow_tab_newline;
                endcase
            end
            if (in_take) begin
                r_byte_count <= i_in_beat.final_byte ? 13'd0 : n_byte_count;
            end
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_beat  <= n_out_beat;
        r_skid_beat <= n_skid_beat;
    end

`include "utf8_text_validator_assert.svh"

    `UTV_ASSERT_IMPLY(a_skid_behind_out, r_skid_valid, r_out_valid)
    `UTV_ASSERT_NEXT(a_final_gives_beat, emit, r_out_valid)
    `UTV_ASSERT_IMPLY(a_ok_matches_kind, r_out_valid,
                      r_out_beat.text_ok == (r_out_beat.fault_kind == utv_pkg::FAULT_NONE))
    `UTV_ASSERT_IMPLY(a_open_seq_has_class, r_state.bytes_still_needed != 2'd0,
                      r_state.sequence_class != 2'd0)

endmodule

`default_nettype wire
